// ===== rtl/cbts_pkg.sv =====
// ----------------------------------------------------------------------------
// cbts_pkg: shared constants and types of the tonal color balance block
// Luma weights, tonal range codes, register indexes and the config bundle.
// ----------------------------------------------------------------------------
package cbts_pkg;

	// Config port
	localparam int CFG_DATA_BITS  = 8;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_TONAL_RANGE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AMT_RED     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AMT_GREEN   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AMT_BLUE    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_LUMA   = 3'd4;

	// Tonal range codes; code 3 means no weighting
	localparam logic [1:0] TONE_LOW  = 2'd0;
	localparam logic [1:0] TONE_MID  = 2'd1;
	localparam logic [1:0] TONE_HIGH = 2'd2;

	// Channel slots in a pixel vector
	localparam int CH_RED     = 0;
	localparam int CH_GREEN   = 1;
	localparam int CH_BLUE    = 2;
	localparam int CH_ALPHA   = 3;
	localparam int NUM_COLORS = 3;

	// Q16 luma weights, sum 65536
	localparam logic [15:0] WEIGHT_R = 16'd19595;
	localparam logic [15:0] WEIGHT_G = 16'd38470;
	localparam logic [15:0] WEIGHT_B = 16'd7471;

	// Q16 tonal weight, 0..65536
	localparam int                  WGT_BITS = 17;
	localparam logic [WGT_BITS-1:0] Q16_ONE  = 17'd65536;
	localparam logic [WGT_BITS-1:0] Q16_HALF = 17'd32768;

	// Shift divisor 400 * 65536 = 2^20 * 25
	localparam int AMT_BITS   = 8;
	localparam int SHIFT_POW2 = 20;
	localparam int SHIFT_ODD  = 25;
	localparam int SHIFT_HALF = 13107200;

	typedef struct packed {
		logic [1:0]                 tonal_range;
		logic [AMT_BITS-1:0]        amt_red;
		logic [AMT_BITS-1:0]        amt_green;
		logic [AMT_BITS-1:0]        amt_blue;
		logic                       keep_luminosity;
	} cfg_t;

endpackage

// ===== rtl/cbts_in_if.sv =====
// ----------------------------------------------------------------------------
// cbts_in_if: input pixel channel
// Valid/ready channel carrying one RGBA pixel per beat.
// ----------------------------------------------------------------------------
interface cbts_in_if #(
	parameter int CHANNEL_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red_in;
	logic [CHANNEL_BITS-1:0] green_in;
	logic [CHANNEL_BITS-1:0] blue_in;
	logic [CHANNEL_BITS-1:0] alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ===== rtl/cbts_out_if.sv =====
// ----------------------------------------------------------------------------
// cbts_out_if: output pixel channel
// Valid/ready channel carrying one adjusted RGBA pixel per beat.
// ----------------------------------------------------------------------------
interface cbts_out_if #(
	parameter int CHANNEL_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red_out;
	logic [CHANNEL_BITS-1:0] green_out;
	logic [CHANNEL_BITS-1:0] blue_out;
	logic [CHANNEL_BITS-1:0] alpha_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ===== rtl/cbts_norm.sv =====
// ----------------------------------------------------------------------------
// cbts_norm: luma and normalized level
// Three stages: weighted sum, rounding plus reciprocal multiply, correction.
// ----------------------------------------------------------------------------
module cbts_norm #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [3:0][CHANNEL_BITS-1:0]         in_pix,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [3:0][CHANNEL_BITS-1:0]         out_pix,
	output logic [CHANNEL_BITS-1:0]              out_luma,
	output logic [cbts_pkg::WGT_BITS-1:0]        out_level
);
	localparam int CB     = CHANNEL_BITS;
	localparam int YSUM_W = CB + 16;
	localparam int M_W    = 18;
	localparam int P_W    = CB + M_W;
	localparam int NM_W   = CB + 35;
	localparam int NUM_W  = CB + 18;
	localparam longint unsigned FS      = (64'd1 << CB) - 64'd1;
	localparam longint unsigned RECIP   = (64'd1 << (CB + 17)) / FS;
	localparam longint unsigned RND_OFS = (FS >> 1) * RECIP;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic [YSUM_W-1:0]        ysum_s1;
	logic [3:0][CB-1:0]       pix_s1;
	logic [CB-1:0]            luma_s2;
	logic [P_W-1:0]           prod_s2;
	logic [3:0][CB-1:0]       pix_s2;
	logic [cbts_pkg::WGT_BITS-1:0] level_s3;
	logic [CB-1:0]            luma_s3;
	logic [3:0][CB-1:0]       pix_s3;

	logic [YSUM_W-1:0]        ysum_d;
	logic [YSUM_W-1:0]        yrnd;
	logic [CB-1:0]            luma_d;
	logic [P_W-1:0]           prod_d;
	logic [NM_W-1:0]          nm;
	logic [M_W-1:0]           q0;
	logic [NUM_W-1:0]         numer;
	logic [NUM_W-1:0]         qfs;
	logic [NUM_W-1:0]         rem;
	logic [M_W-1:0]           lvl_full;

	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1: Q16 weighted sum
	assign ysum_d = YSUM_W'(in_pix[cbts_pkg::CH_RED])   * YSUM_W'(cbts_pkg::WEIGHT_R)
	              + YSUM_W'(in_pix[cbts_pkg::CH_GREEN]) * YSUM_W'(cbts_pkg::WEIGHT_G)
	              + YSUM_W'(in_pix[cbts_pkg::CH_BLUE])  * YSUM_W'(cbts_pkg::WEIGHT_B);

	// stage 2: round to luma, multiply by reciprocal of full scale
	assign yrnd   = ysum_s1 + YSUM_W'(32768);
	assign luma_d = yrnd[YSUM_W-1:16];
	assign prod_d = P_W'(luma_d) * P_W'(RECIP);

	// stage 3: estimate may be one low, fix with remainder
	assign nm       = NM_W'({prod_s2, 16'd0}) + NM_W'(RND_OFS);
	assign q0       = nm[NM_W-1:CB+17];
	assign numer    = NUM_W'({luma_s2, 16'd0}) + NUM_W'(FS >> 1);
	assign qfs      = (NUM_W'(q0) << CB) - NUM_W'(q0);
	assign rem      = numer - qfs;
	assign lvl_full = q0 + M_W'(rem >= NUM_W'(FS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ysum_s1 <= ysum_d;
			pix_s1  <= in_pix;
		end
		if (rdy_s2) begin
			luma_s2 <= luma_d;
			prod_s2 <= prod_d;
			pix_s2  <= pix_s1;
		end
		if (rdy_s3) begin
			level_s3 <= lvl_full[cbts_pkg::WGT_BITS-1:0];
			luma_s3  <= luma_s2;
			pix_s3   <= pix_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_pix   = pix_s3;
	assign out_luma  = luma_s3;
	assign out_level = level_s3;

endmodule

// ===== rtl/cbts_weight.sv =====
// ----------------------------------------------------------------------------
// cbts_weight: tonal weight curve
// Three stages: first products, curve select / cubic product, final round.
// ----------------------------------------------------------------------------
module cbts_weight #(
	parameter int SIDE_W = 80
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    tonal_range,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cbts_pkg::WGT_BITS-1:0] in_level,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cbts_pkg::WGT_BITS-1:0] out_weight,
	output logic [SIDE_W-1:0]             out_side
);
	localparam int WB = cbts_pkg::WGT_BITS;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic [32:0]       sh_s1;
	logic [32:0]       ll_s1;
	logic [WB-1:0]     wmid_s1;
	logic [WB-1:0]     lvl_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [48:0]       hp_s2;
	logic [WB-1:0]     wother_s2;
	logic [SIDE_W-1:0] side_s2;
	logic [WB-1:0]     weight_s3;
	logic [SIDE_W-1:0] side_s3;

	logic [33:0]   sh_full;
	logic [33:0]   ll_full;
	logic [WB-1:0] wmid_d;
	logic [35:0]   shr;
	logic [17:0]   tfac;
	logic [50:0]   hp_full;
	logic [WB-1:0] wother_d;
	logic [49:0]   hr;
	logic [WB-1:0] weight_d;

	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1: l(1-l), l*l, triangle
	assign sh_full = 34'(in_level) * 34'(cbts_pkg::Q16_ONE - in_level);
	assign ll_full = 34'(in_level) * 34'(in_level);
	assign wmid_d  = (in_level < cbts_pkg::Q16_HALF) ? WB'({in_level, 1'b0})
	                 : WB'({cbts_pkg::Q16_ONE - in_level, 1'b0});

	// stage 2: shadows round, smoothstep cubic product
	assign shr     = 36'({sh_s1, 2'b00}) + 36'd32768;
	assign tfac    = 18'd196608 - 18'({lvl_s1, 1'b0});
	assign hp_full = 51'(ll_s1) * 51'(tfac);

	always_comb begin
		case (tonal_range)
			cbts_pkg::TONE_LOW: wother_d = shr[32:16];
			cbts_pkg::TONE_MID: wother_d = wmid_s1;
			default:            wother_d = '0;
		endcase
	end

	// stage 3: highlights round
	assign hr       = 50'(hp_s2) + 50'd2147483648;
	assign weight_d = (tonal_range == cbts_pkg::TONE_HIGH) ? hr[48:32] : wother_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sh_s1   <= sh_full[32:0];
			ll_s1   <= ll_full[32:0];
			wmid_s1 <= wmid_d;
			lvl_s1  <= in_level;
			side_s1 <= in_side;
		end
		if (rdy_s2) begin
			hp_s2     <= hp_full[48:0];
			wother_s2 <= wother_d;
			side_s2   <= side_s1;
		end
		if (rdy_s3) begin
			weight_s3 <= weight_d;
			side_s3   <= side_s2;
		end
	end

	assign out_valid  = vld_s3;
	assign out_weight = weight_s3;
	assign out_side   = side_s3;

endmodule

// ===== rtl/cbts_shift.sv =====
// ----------------------------------------------------------------------------
// cbts_shift: per-channel color shift
// amount * weight * FS / (400 * 65536), halves away from zero, three lanes.
// ----------------------------------------------------------------------------
module cbts_shift #(
	parameter int CHANNEL_BITS = 16,
	parameter int SIDE_W       = 32
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic [cbts_pkg::NUM_COLORS-1:0][cbts_pkg::AMT_BITS-1:0] amount,
	input  logic                                                   in_valid,
	output logic                                                   in_ready,
	input  logic [cbts_pkg::WGT_BITS-1:0]                          in_weight,
	input  logic [cbts_pkg::NUM_COLORS-1:0][CHANNEL_BITS-1:0]      in_chan,
	input  logic [SIDE_W-1:0]                                      in_side,
	output logic                                                   out_valid,
	input  logic                                                   out_ready,
	output logic [cbts_pkg::NUM_COLORS-1:0][CHANNEL_BITS+1:0]      out_chan,
	output logic [SIDE_W-1:0]                                      out_side
);
	localparam int CB    = CHANNEL_BITS;
	localparam int NC    = cbts_pkg::NUM_COLORS;
	localparam int AB    = cbts_pkg::AMT_BITS;
	localparam int AW_W  = 24;
	localparam int NUM_W = CB + 25;
	localparam int XW    = NUM_W - cbts_pkg::SHIFT_POW2;
	localparam int PX_W  = 2 * XW - 4;
	localparam int Q_W   = XW - 4;
	localparam int NW    = CB + 2;
	localparam longint unsigned RECIP25 = (64'd1 << XW) / cbts_pkg::SHIFT_ODD;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic [NC-1:0][AW_W-1:0] aw_s1;
	logic [NC-1:0]           neg_s1;
	logic [NC-1:0][CB-1:0]   chan_s1;
	logic [SIDE_W-1:0]       side_s1;
	logic [NC-1:0][XW-1:0]   x_s2;
	logic [NC-1:0][PX_W-1:0] px_s2;
	logic [NC-1:0]           neg_s2;
	logic [NC-1:0][CB-1:0]   chan_s2;
	logic [SIDE_W-1:0]       side_s2;
	logic [NC-1:0][NW-1:0]   chan_s3;
	logic [SIDE_W-1:0]       side_s3;

	logic [NC-1:0][AW_W-1:0]  aw_d;
	logic [NC-1:0][AB-1:0]    mag;
	logic [NC-1:0][NUM_W-1:0] num;
	logic [NC-1:0][XW-1:0]    x_d;
	logic [NC-1:0][PX_W-1:0]  px_d;
	logic [NC-1:0][Q_W-1:0]   q0;
	logic [NC-1:0][XW:0]      q25;
	logic [NC-1:0][XW:0]      rem;
	logic [NC-1:0][Q_W-1:0]   q;
	logic [NC-1:0][NW-1:0]   chan_d;

	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			// stage 1: |amount| * weight
			mag[c]  = amount[c][AB-1] ? AB'(-amount[c]) : amount[c];
			aw_d[c] = AW_W'(mag[c]) * AW_W'(in_weight);
			// stage 2: times FS by shift-subtract, drop 2^20, reciprocal of 25
			num[c]  = (NUM_W'(aw_s1[c]) << CB) - NUM_W'(aw_s1[c])
			        + NUM_W'(cbts_pkg::SHIFT_HALF);
			x_d[c]  = num[c][NUM_W-1:cbts_pkg::SHIFT_POW2];
			px_d[c] = PX_W'(x_d[c]) * PX_W'(RECIP25);
			// stage 3: quotient may be one low; apply with sign
			q0[c]   = px_s2[c][PX_W-1:XW];
			q25[c]  = ((XW+1)'(q0[c]) << 4) + ((XW+1)'(q0[c]) << 3) + (XW+1)'(q0[c]);
			rem[c]  = (XW+1)'(x_s2[c]) - q25[c];
			q[c]    = q0[c] + Q_W'(rem[c] >= (XW+1)'(cbts_pkg::SHIFT_ODD));
			chan_d[c] = neg_s2[c] ? NW'(chan_s2[c]) - NW'(q[c])
			                      : NW'(chan_s2[c]) + NW'(q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			aw_s1   <= aw_d;
			for (int c = 0; c < NC; c++) begin
				neg_s1[c] <= amount[c][AB-1];
			end
			chan_s1 <= in_chan;
			side_s1 <= in_side;
		end
		if (rdy_s2) begin
			x_s2    <= x_d;
			px_s2   <= px_d;
			neg_s2  <= neg_s1;
			chan_s2 <= chan_s1;
			side_s2 <= side_s1;
		end
		if (rdy_s3) begin
			chan_s3 <= chan_d;
			side_s3 <= side_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_chan  = chan_s3;
	assign out_side  = side_s3;

endmodule

// ===== rtl/cbts_luma_fix.sv =====
// ----------------------------------------------------------------------------
// cbts_luma_fix: luminosity restore and clamp
// Stage 1 re-measures luma of shifted channels, stage 2 adds back and clamps.
// ----------------------------------------------------------------------------
module cbts_luma_fix #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              keep_luminosity,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  logic [cbts_pkg::NUM_COLORS-1:0][CHANNEL_BITS+1:0] in_chan,
	input  logic [CHANNEL_BITS-1:0]                           in_luma,
	input  logic [CHANNEL_BITS-1:0]                           in_alpha,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic [3:0][CHANNEL_BITS-1:0]                      out_pix
);
	localparam int CB   = CHANNEL_BITS;
	localparam int NC   = cbts_pkg::NUM_COLORS;
	localparam int NW   = CB + 2;
	localparam int LS_W = CB + 18;
	localparam int DW   = CB + 4;
	localparam logic [CB-1:0] FS = '1;

	logic vld_s1, vld_s2;
	logic rdy_s1, rdy_s2;

	logic [LS_W-1:0]       lsum_s1;
	logic [NC-1:0][NW-1:0] chan_s1;
	logic [CB-1:0]         luma_s1;
	logic [CB-1:0]         alpha_s1;
	logic [3:0][CB-1:0]    pix_s2;

	logic [NC-1:0][LS_W-1:0] sx;
	logic [LS_W-1:0]         lsum_d;
	logic                    neg;
	logic [LS_W-1:0]         mag;
	logic [LS_W-1:0]         rnd;
	logic [DW-1:0]           y2;
	logic [DW-1:0]           d;
	logic [NC-1:0][DW-1:0]   adj;
	logic [3:0][CB-1:0]      pix_d;

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1: two's complement luma sum of shifted channels
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			sx[c] = {{(LS_W-NW){in_chan[c][NW-1]}}, in_chan[c]};
		end
	end

	assign lsum_d = sx[cbts_pkg::CH_RED]   * LS_W'(cbts_pkg::WEIGHT_R)
	              + sx[cbts_pkg::CH_GREEN] * LS_W'(cbts_pkg::WEIGHT_G)
	              + sx[cbts_pkg::CH_BLUE]  * LS_W'(cbts_pkg::WEIGHT_B);

	// stage 2: round half away from zero, restore, clamp
	assign neg = lsum_s1[LS_W-1];
	assign mag = neg ? LS_W'(0) - lsum_s1 : lsum_s1;
	assign rnd = mag + LS_W'(32768);
	assign y2  = neg ? DW'(0) - DW'(rnd[LS_W-1:16]) : DW'(rnd[LS_W-1:16]);
	assign d   = DW'(luma_s1) - y2;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			adj[c] = {{(DW-NW){chan_s1[c][NW-1]}}, chan_s1[c]}
			       + (keep_luminosity ? d : DW'(0));
			if (adj[c][DW-1]) begin
				pix_d[c] = '0;
			end else if (adj[c][DW-2:0] > (DW-1)'(FS)) begin
				pix_d[c] = FS;
			end else begin
				pix_d[c] = adj[c][CB-1:0];
			end
		end
		pix_d[cbts_pkg::CH_ALPHA] = alpha_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			lsum_s1  <= lsum_d;
			chan_s1  <= in_chan;
			luma_s1  <= in_luma;
			alpha_s1 <= in_alpha;
		end
		if (rdy_s2) begin
			pix_s2 <= pix_d;
		end
	end

	assign out_valid = vld_s2;
	assign out_pix   = pix_s2;

endmodule

// ===== rtl/color_balance_tonal_shift.sv =====
// ----------------------------------------------------------------------------
// color_balance_tonal_shift: tonal color balance on an RGBA pixel stream
// Shifts red/green/blue along three color axes, weighted by a tonal curve of
// the pixel's luma, optionally restores luma, clamps; alpha passes through.
//
// Usage:
//   pixel  - valid/ready sink, one RGBA pixel per beat.
//   result - valid/ready source, one adjusted pixel per beat, same order.
//   cfg_*  - write port: cfg_we, cfg_index (register 0..4), cfg_data. Write
//            only while the pipeline is empty; settings apply to every stage.
//   Throughput: one pixel per clock while result.ready stays high, with no gaps between beats.
//   Stages: eleven register stages (luma 3, tonal weight 3, color shift 3,
//   luma restore 2), each holding roughly one multiply or one wide add and
//   compare.
//   Stall: every stage has its own valid bit and loads when it is empty or
//   the next stage moves, so bubbles collapse. Ready runs combinationally
//   from result.ready back to pixel.ready; once all eleven stages hold a
//   pixel, a stalled result drops pixel.ready in the same cycle. Nothing is
//   dropped or repeated.
//   Reset (arst_n low): all valid bits clear, so pixel.ready already reads
//   high during reset; send no pixel until release. Registers return to
//   midtones, zero amounts, luma restore on.
// ----------------------------------------------------------------------------
module color_balance_tonal_shift #(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [cbts_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [cbts_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	cbts_in_if.sink                                pixel,
	cbts_out_if.source                             result
);
	localparam int CB     = CHANNEL_BITS;
	localparam int NC     = cbts_pkg::NUM_COLORS;
	localparam int WB     = cbts_pkg::WGT_BITS;
	localparam int SIDE1  = 5 * CB;    // rgba + luma through the weight stages
	localparam int SIDE2  = 2 * CB;    // alpha + luma through the shift stages

	cbts_pkg::cfg_t cfg_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tonal_range     <= cbts_pkg::TONE_MID;
			cfg_q.amt_red         <= '0;
			cfg_q.amt_green       <= '0;
			cfg_q.amt_blue        <= '0;
			cfg_q.keep_luminosity <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				cbts_pkg::REG_TONAL_RANGE: cfg_q.tonal_range     <= cfg_data[1:0];
				cbts_pkg::REG_AMT_RED:     cfg_q.amt_red         <= cfg_data;
				cbts_pkg::REG_AMT_GREEN:   cfg_q.amt_green       <= cfg_data;
				cbts_pkg::REG_AMT_BLUE:    cfg_q.amt_blue        <= cfg_data;
				cbts_pkg::REG_KEEP_LUMA:   cfg_q.keep_luminosity <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// luma and level
	logic [3:0][CB-1:0] in_pix;
	logic               nrm_valid, nrm_ready;
	logic [3:0][CB-1:0] nrm_pix;
	logic [CB-1:0]      nrm_luma;
	logic [WB-1:0]      nrm_level;

	assign in_pix[cbts_pkg::CH_RED]   = pixel.red_in;
	assign in_pix[cbts_pkg::CH_GREEN] = pixel.green_in;
	assign in_pix[cbts_pkg::CH_BLUE]  = pixel.blue_in;
	assign in_pix[cbts_pkg::CH_ALPHA] = pixel.alpha_in;

	cbts_norm #(
		.CHANNEL_BITS(CB)
	) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (pixel.ready),
		.in_pix   (in_pix),
		.out_valid(nrm_valid),
		.out_ready(nrm_ready),
		.out_pix  (nrm_pix),
		.out_luma (nrm_luma),
		.out_level(nrm_level)
	);

	// tonal weight; pixel and luma ride along
	logic             wgt_valid, wgt_ready;
	logic [WB-1:0]    wgt_weight;
	logic [SIDE1-1:0] wgt_side;
	logic [3:0][CB-1:0] wgt_pix;
	logic [CB-1:0]    wgt_luma;

	cbts_weight #(
		.SIDE_W(SIDE1)
	) u_weight (
		.clk        (clk),
		.arst_n     (arst_n),
		.tonal_range(cfg_q.tonal_range),
		.in_valid   (nrm_valid),
		.in_ready   (nrm_ready),
		.in_level   (nrm_level),
		.in_side    ({nrm_pix, nrm_luma}),
		.out_valid  (wgt_valid),
		.out_ready  (wgt_ready),
		.out_weight (wgt_weight),
		.out_side   (wgt_side)
	);

	assign wgt_pix  = wgt_side[SIDE1-1:CB];
	assign wgt_luma = wgt_side[CB-1:0];

	// color shift per channel
	logic [NC-1:0][cbts_pkg::AMT_BITS-1:0] amounts;
	logic [NC-1:0][CB-1:0]                 sh_in;
	logic                                  sh_valid, sh_ready;
	logic [NC-1:0][CB+1:0]                 sh_chan;
	logic [SIDE2-1:0]                      sh_side;

	assign amounts[cbts_pkg::CH_RED]   = cfg_q.amt_red;
	assign amounts[cbts_pkg::CH_GREEN] = cfg_q.amt_green;
	assign amounts[cbts_pkg::CH_BLUE]  = cfg_q.amt_blue;
	assign sh_in = wgt_pix[NC-1:0];

	cbts_shift #(
		.CHANNEL_BITS(CB),
		.SIDE_W      (SIDE2)
	) u_shift (
		.clk      (clk),
		.arst_n   (arst_n),
		.amount   (amounts),
		.in_valid (wgt_valid),
		.in_ready (wgt_ready),
		.in_weight(wgt_weight),
		.in_chan  (sh_in),
		.in_side  ({wgt_pix[cbts_pkg::CH_ALPHA], wgt_luma}),
		.out_valid(sh_valid),
		.out_ready(sh_ready),
		.out_chan (sh_chan),
		.out_side (sh_side)
	);

	// luma restore, clamp, output register
	logic [3:0][CB-1:0] out_pix;

	cbts_luma_fix #(
		.CHANNEL_BITS(CB)
	) u_luma_fix (
		.clk            (clk),
		.arst_n         (arst_n),
		.keep_luminosity(cfg_q.keep_luminosity),
		.in_valid       (sh_valid),
		.in_ready       (sh_ready),
		.in_chan        (sh_chan),
		.in_luma        (sh_side[CB-1:0]),
		.in_alpha       (sh_side[SIDE2-1:CB]),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.out_pix        (out_pix)
	);

	assign result.red_out   = out_pix[cbts_pkg::CH_RED];
	assign result.green_out = out_pix[cbts_pkg::CH_GREEN];
	assign result.blue_out  = out_pix[cbts_pkg::CH_BLUE];
	assign result.alpha_out = out_pix[cbts_pkg::CH_ALPHA];

endmodule

// ===== tb/color_balance_tonal_shift_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_balance_tonal_shift_tb: self-checking bench for the tonal color balance
// Streams RGBA pixels through the block under several register settings and
// compares every result beat, field by field, with a built-in fixed-point
// predictor. Both sides idle at random; the output side also stalls for long.
// ----------------------------------------------------------------------------
module color_balance_tonal_shift_tb;

	localparam int CHAN_BITS = 16;
	localparam int PIPE_LATENCY = 11;
	localparam int IDLE_PCT = 16;
	localparam int LONG_HOLD = 120;       // output stall long enough to back up the input
	localparam int WATCHDOG_LIMIT = 5000; // cycles with no beat on either side
	localparam int RANDOM_ITEMS = 1800;
	localparam int FIRST_RANDOM_RUN = 300;
	// beat window on the input side in which neither side idles
	localparam int STEADY_FROM = 900;
	localparam int STEADY_TO = 1200;

	// range code 3 has no name in the package: it disables weighting
	localparam logic [1:0] TONE_NONE = 2'd3;

	// fixed-point constants of the predictor
	localparam longint FULL_SCALE = (longint'(1) << CHAN_BITS) - 1;
	localparam longint ONE_Q16 = 65536;
	localparam longint LUMA_WR = 19595;
	localparam longint LUMA_WG = 38470;
	localparam longint LUMA_WB = 7471;
	localparam longint SHIFT_DEN = 400 * 65536;
	localparam longint HALF_Q32 = longint'(1) << 31;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
		logic [CHAN_BITS-1:0] alpha;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [cbts_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [cbts_pkg::CFG_DATA_BITS-1:0] cfg_data;

	cbts_in_if #(.CHANNEL_BITS(CHAN_BITS)) pixel_if ();
	cbts_out_if #(.CHANNEL_BITS(CHAN_BITS)) result_if ();

	color_balance_tonal_shift #(
		.CHANNEL_BITS(CHAN_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel    (pixel_if),
		.result   (result_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block's registers; only changes while the pipe is empty
	cbts_pkg::cfg_t balance_cfg;

	pixel_t pending_pixels[$];   // waiting to be driven
	pixel_t expected_pixels[$];  // predicted results, oldest first
	pixel_t next_pixel;
	pixel_t want_pixel;

	int in_beats;
	int out_beats;
	int error_count = 0;
	int settings_count = 0;
	int stall_left;
	logic long_hold_done;
	int quiet_cycles;
	logic steady;

	// Corner pixels for the directed part: black, white, grays, primaries
	pixel_t corner_pixels [8] = '{
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{16'h8000, 16'h8000, 16'h8000, 16'h1234},
		'{16'h4000, 16'h4000, 16'h4000, 16'hFFFF},
		'{16'hC000, 16'hC000, 16'hC000, 16'h0000},
		'{16'hFFFF, 16'h0000, 16'h0000, 16'h5555},
		'{16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA},
		'{16'h0000, 16'h0000, 16'hFFFF, 16'h8001}
	};

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// signed division by a positive divisor, halves away from zero
	function automatic longint round_div(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// luma works on signed channels too (after the shift they may leave 0..FS)
	function automatic longint luma_of(longint r, longint g, longint b);
		return round_div(r * LUMA_WR + g * LUMA_WG + b * LUMA_WB, ONE_Q16);
	endfunction

	// Q16 tonal weight of a luma value for the given range code
	function automatic longint tone_weight(longint y, logic [1:0] range_code);
		longint lvl;
		lvl = (y * ONE_Q16 + FULL_SCALE / 2) / FULL_SCALE;
		if (lvl < 0)
			lvl = 0;
		if (lvl > ONE_Q16)
			lvl = ONE_Q16;
		case (range_code)
			cbts_pkg::TONE_LOW: begin
				return (4 * lvl * (ONE_Q16 - lvl) + 32768) >> 16;
			end
			cbts_pkg::TONE_MID: begin
				return (lvl < 32768) ? 2 * lvl : 2 * (ONE_Q16 - lvl);
			end
			cbts_pkg::TONE_HIGH: begin
				// smoothstep l*l*(3-2l), all in Q16
				return (lvl * lvl * (3 * ONE_Q16 - 2 * lvl) + HALF_Q32) >> 32;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic logic [CHAN_BITS-1:0] clamp_channel(longint v);
		if (v < 0)
			return '0;
		if (v > FULL_SCALE)
			return FULL_SCALE[CHAN_BITS-1:0];
		return v[CHAN_BITS-1:0];
	endfunction

	function automatic pixel_t balance_pixel(pixel_t px, cbts_pkg::cfg_t cfg);
		longint r, g, b, y, w, nr, ng, nb, lost;
		pixel_t res;
		r = px.red;
		g = px.green;
		b = px.blue;
		y = luma_of(r, g, b);
		w = tone_weight(y, cfg.tonal_range);
		nr = r + round_div(longint'($signed(cfg.amt_red)) * w * FULL_SCALE, SHIFT_DEN);
		ng = g + round_div(longint'($signed(cfg.amt_green)) * w * FULL_SCALE, SHIFT_DEN);
		nb = b + round_div(longint'($signed(cfg.amt_blue)) * w * FULL_SCALE, SHIFT_DEN);
		if (cfg.keep_luminosity) begin
			// put the luma lost by the shift back into all three channels
			lost = y - luma_of(nr, ng, nb);
			nr += lost;
			ng += lost;
			nb += lost;
		end
		res.red = clamp_channel(nr);
		res.green = clamp_channel(ng);
		res.blue = clamp_channel(nb);
		res.alpha = px.alpha;
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// Reporting
	// ---------------------------------------------------------------------

	// one line per mismatch; printing stops after a while, counting does not
	task automatic report_mismatch(string what, int beat, longint want, longint got);
		if (error_count < 40)
			$display("[%0t] MISMATCH %s at result beat %0d: want 0x%0h got 0x%0h",
				$realtime, what, beat, want, got);
		error_count++;
	endtask

	// ---------------------------------------------------------------------
	// Register writes (pipe must be empty)
	// ---------------------------------------------------------------------

	// range and keep words carry random upper bits; the block only looks at
	// the low bits of those registers
	task automatic apply_settings(logic [7:0] range_word, logic [7:0] amt_r,
		logic [7:0] amt_g, logic [7:0] amt_b, logic [7:0] keep_word);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= cbts_pkg::REG_TONAL_RANGE;
		cfg_data <= range_word;
		@(posedge clk);
		cfg_index <= cbts_pkg::REG_AMT_RED;
		cfg_data <= amt_r;
		@(posedge clk);
		cfg_index <= cbts_pkg::REG_AMT_GREEN;
		cfg_data <= amt_g;
		@(posedge clk);
		cfg_index <= cbts_pkg::REG_AMT_BLUE;
		cfg_data <= amt_b;
		@(posedge clk);
		cfg_index <= cbts_pkg::REG_KEEP_LUMA;
		cfg_data <= keep_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		balance_cfg.tonal_range = range_word[1:0];
		balance_cfg.amt_red = amt_r;
		balance_cfg.amt_green = amt_g;
		balance_cfg.amt_blue = amt_b;
		balance_cfg.keep_luminosity = keep_word[0];
		settings_count++;
	endtask

	// sampled at the falling edge so that everything of the rising edge
	// has settled
	task automatic wait_pipe_empty();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || pixel_if.valid || expected_pixels.size() != 0);
	endtask

	function automatic logic [7:0] pick_amount();
		logic [7:0] corner [5] = '{8'h80, 8'h7F, 8'h9C, 8'h64, 8'h00};
		if ($urandom_range(0, 3) == 0)
			return corner[$urandom_range(0, 4)];
		return 8'($urandom_range(0, 255));
	endfunction

	// ---------------------------------------------------------------------
	// Input driver: one beat per accepted pixel, predicted at acceptance
	// ---------------------------------------------------------------------
	assign steady = (in_beats >= STEADY_FROM) && (in_beats < STEADY_TO);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_if.valid <= 1'b0;
			pixel_if.red_in <= '0;
			pixel_if.green_in <= '0;
			pixel_if.blue_in <= '0;
			pixel_if.alpha_in <= '0;
			in_beats <= 0;
		end else begin
			if (pixel_if.valid && pixel_if.ready) begin
				expected_pixels.push_back(balance_pixel(pixel_t'({pixel_if.red_in,
					pixel_if.green_in, pixel_if.blue_in, pixel_if.alpha_in}), balance_cfg));
				in_beats <= in_beats + 1;
			end
			if (!pixel_if.valid || pixel_if.ready) begin
				if (pending_pixels.size() != 0 &&
					(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_pixel = pending_pixels.pop_front();
					pixel_if.valid <= 1'b1;
					pixel_if.red_in <= next_pixel.red;
					pixel_if.green_in <= next_pixel.green;
					pixel_if.blue_in <= next_pixel.blue;
					pixel_if.alpha_in <= next_pixel.alpha;
				end else begin
					pixel_if.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output ready: random idling plus one long stall early in the first
	// long random run, so the pipe fills and pushes back on the input
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_if.ready <= 1'b0;
		end else if (!long_hold_done && in_beats >= 60) begin
			long_hold_done <= 1'b1;
			stall_left <= LONG_HOLD;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------------
	// Result monitor
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_beats <= 0;
		end else if (result_if.valid && result_if.ready) begin
			out_beats <= out_beats + 1;
			if (expected_pixels.size() == 0) begin
				report_mismatch("result beat with none expected, red", out_beats, 0,
					result_if.red_out);
			end else begin
				want_pixel = expected_pixels.pop_front();
				if (result_if.red_out !== want_pixel.red)
					report_mismatch("red_out", out_beats, want_pixel.red, result_if.red_out);
				if (result_if.green_out !== want_pixel.green)
					report_mismatch("green_out", out_beats, want_pixel.green,
						result_if.green_out);
				if (result_if.blue_out !== want_pixel.blue)
					report_mismatch("blue_out", out_beats, want_pixel.blue, result_if.blue_out);
				if (result_if.alpha_out !== want_pixel.alpha)
					report_mismatch("alpha_out", out_beats, want_pixel.alpha,
						result_if.alpha_out);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: too long without a beat on either side ends the run
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (pixel_if.valid && pixel_if.ready) ||
			(result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_pixels.size());
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		int random_items;
		int run_len;
		int mode;
		logic [CHAN_BITS-1:0] base;
		pixel_t px;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		// register values after reset: midtones, no shift, luma kept
		balance_cfg = '{tonal_range: cbts_pkg::TONE_MID, amt_red: '0, amt_green: '0,
			amt_blue: '0, keep_luminosity: 1'b1};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings first (no write), then corner settings
		for (int k = 0; k < 6; k++) begin
			case (k)
				1: apply_settings({6'd0, cbts_pkg::TONE_LOW}, 8'h7F, 8'h7F, 8'h7F, 8'h00);
				2: apply_settings({6'h3F, cbts_pkg::TONE_HIGH}, 8'h80, 8'h80, 8'h80, 8'h01);
				// unused range code: weight zero, pixel passes unchanged
				3: apply_settings({6'd0, TONE_NONE}, 8'h64, 8'h9C, 8'h7F, 8'h01);
				4: apply_settings({6'h2A, cbts_pkg::TONE_MID}, 8'h9C, 8'h64, 8'h80, 8'hFE);
				5: apply_settings({6'd0, cbts_pkg::TONE_LOW}, 8'h80, 8'h7F, 8'h9C, 8'h81);
				default: ;
			endcase
			for (int j = 0; j < 4; j++)
				pending_pixels.push_back(corner_pixels[(k * 3 + j) % 8]);
			// sender holds until the pipe has drained before new settings
			wait_pipe_empty();
		end

		// Random runs, each under fresh random settings
		random_items = 0;
		run_len = FIRST_RANDOM_RUN;
		while (random_items < RANDOM_ITEMS) begin
			if (run_len > RANDOM_ITEMS - random_items)
				run_len = RANDOM_ITEMS - random_items;
			apply_settings(8'($urandom_range(0, 255)), pick_amount(), pick_amount(),
				pick_amount(), 8'($urandom_range(0, 255)));
			for (int n = 0; n < run_len; n++) begin
				mode = $urandom_range(0, 9);
				px.alpha = CHAN_BITS'($urandom);
				if (mode < 6) begin
					px.red = CHAN_BITS'($urandom);
					px.green = CHAN_BITS'($urandom);
					px.blue = CHAN_BITS'($urandom);
				end else if (mode < 8) begin
					// near gray: luma spread over the whole range, large weights
					base = CHAN_BITS'($urandom);
					px.red = base ^ CHAN_BITS'($urandom_range(0, 4095));
					px.green = base ^ CHAN_BITS'($urandom_range(0, 4095));
					px.blue = base ^ CHAN_BITS'($urandom_range(0, 4095));
				end else if (mode == 8) begin
					// saturated channels, drives clamping at both ends
					px.red = $urandom_range(0, 1) ? '1 : '0;
					px.green = $urandom_range(0, 1) ? '1 : '0;
					px.blue = $urandom_range(0, 1) ? '1 : '0;
				end else begin
					px.red = $urandom_range(0, 1) ? '1 : CHAN_BITS'($urandom);
					px.green = $urandom_range(0, 1) ? '0 : CHAN_BITS'($urandom);
					px.blue = CHAN_BITS'($urandom);
				end
				pending_pixels.push_back(px);
			end
			random_items += run_len;
			wait_pipe_empty();
			run_len = $urandom_range(40, 200);
		end

		wait_pipe_empty();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (expected_pixels.size() != 0)
			report_mismatch("results never delivered, count", out_beats, 0,
				expected_pixels.size());

		$display("run covered %0d pixels in, %0d results checked, %0d register settings,",
			in_beats, out_beats, settings_count);
		$display("with random idling, one long output stall and drains between settings");
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", error_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cbts_pkg.sv
rtl/cbts_in_if.sv
rtl/cbts_out_if.sv
rtl/cbts_norm.sv
rtl/cbts_weight.sv
rtl/cbts_shift.sv
rtl/cbts_luma_fix.sv
rtl/color_balance_tonal_shift.sv
tb/color_balance_tonal_shift_tb.sv
